### hw/rtl/nket_pkg.sv
package nket_pkg;

  typedef enum logic [3:0] {
    CmdClear     = 4'd0,
    CmdFind      = 4'd1,
    CmdDeclare   = 4'd2,
    CmdSetSig    = 4'd3,
    CmdSetParam  = 4'd4,
    CmdSetStart  = 4'd5,
    CmdReadEntry = 4'd6,
    CmdReadParam = 4'd7,
    CmdSavepoint = 4'd8,
    CmdRollback  = 4'd9,
    CmdSnapshot  = 4'd10
  } cmd_e;

  // Width of a stored type code; the type ports carry 4 bits.
  localparam int TypeBits = 4;

  localparam logic [15:0] StartDefault = 16'hFFFF;
  localparam logic [7:0]  CountDefault = 8'hFF;
  localparam logic [3:0]  TypeVoid     = 4'd0;
  localparam logic [3:0]  TypeUnknown  = 4'd0;

  // Control handed down the cell chain.
  typedef struct packed {
    logic [63:0] name;
    logic [63:0] mask;
    logic        tail_zero;
    logic        active;
  } probe_t;

endpackage

### hw/rtl/name_keyed_entry_table.sv
// Keyed entry table. A start is taken when busy is low; every command
// returns one result strobed by done_o for one cycle, which the receiver must
// take then: it cannot stall. Find and declare run the probe down a chain of
// TABLE_DEPTH compare cells, one slot per cycle, and strobe their result
// once the walk reaches the last cell; all other commands strobe after the
// read state (register read, then result). busy stays high through the
// strobe cycle.
// Clear and rollback drop entries by moving the live count, so no clearing
// sweep.
module name_keyed_entry_table #(
  parameter int TABLE_DEPTH    = 64,
  parameter int NAME_BYTES     = 8,
  parameter int TRACKED_PARAMS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         command_i,
  input  logic [63:0]        name_packed_i,
  input  logic [7:0]         name_length_i,
  input  logic [7:0]         entry_index_i,
  input  logic [7:0]         param_slot_i,
  input  logic [7:0]         param_total_i,
  input  logic               returns_flag_i,
  input  logic [3:0]         type_code_in_i,
  input  logic [15:0]        start_offset_i,
  input  logic [7:0]         saved_total_i,
  output logic               done_o,
  output logic signed [6:0]  found_index_o,
  output logic [6:0]         entry_total_o,
  output logic [15:0]        start_out_o,
  output logic [7:0]         param_total_out_o,
  output logic               returns_out_o,
  output logic [3:0]         type_code_out_o
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int PW  = (TRACKED_PARAMS > 1) ? $clog2(TRACKED_PARAMS) : 1;
  localparam int CMP = NAME_BYTES - 1;
  localparam int TB  = nket_pkg::TypeBits;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRead = 4'b0010,
    StWalk = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Latched command.
  logic [3:0]  cmd_q;
  logic [63:0] name_q;
  logic [7:0]  len_q, idx_q, pslot_q, ptot_q, saved_q;
  logic        rflag_q;
  logic [TB-1:0] tcode_q;
  logic [15:0] soff_q;

  // Table storage.
  logic [63:0] names_q [TABLE_DEPTH];
  logic [15:0] starts_q [TABLE_DEPTH];
  logic [7:0]  pcnt_q [TABLE_DEPTH];
  logic        rflg_q [TABLE_DEPTH];
  logic [TB-1:0] rtype_q [TABLE_DEPTH];
  logic [TB-1:0] ptype_mem [TABLE_DEPTH << PW];
  logic [TB-1:0] ptype_rd_q;
  logic [CW-1:0] count_q;

  logic        snap_valid_q;
  logic [IW-1:0] snap_slot_q;
  logic [15:0] snap_start_q;
  logic [7:0]  snap_pcnt_q;
  logic        snap_rflg_q;
  logic [TB-1:0] snap_rtype_q;

  logic [7:0] walk_q;
  logic       hit_seen_q;
  logic [IW-1:0] hit_idx_q;

  // Result registers.
  logic        done_q, done_d;
  logic signed [6:0] found_q, found_d;
  logic [15:0] so_q, so_d;
  logic [7:0]  po_q, po_d;
  logic        ro_q, ro_d;
  logic [3:0]  to_q, to_d;

  logic live;
  logic pslot_ok;
  assign live     = ({24'd0, idx_q} < 32'(count_q)) && ({24'd0, idx_q} < TABLE_DEPTH);
  assign pslot_ok = {24'd0, pslot_q} < TRACKED_PARAMS;
  logic [IW-1:0] idx_w;
  assign idx_w = idx_q[IW-1:0];
  logic [PW-1:0] pslot_w;
  assign pslot_w = (TRACKED_PARAMS > 1) ? pslot_q[PW-1:0] : '0;

  // Build probe masks from the name length.
  logic [7:0]  n_cmp;
  logic [63:0] cmp_mask, tail_mask, len_mask;
  always_comb begin
    n_cmp = (len_q < 8'(CMP)) ? len_q : 8'(CMP);
    cmp_mask = '0;
    len_mask = '0;
    tail_mask = '0;
    for (int b = 0; b < 8; b++) begin
      if (8'(b) < n_cmp) cmp_mask[b*8 +: 8] = 8'hFF;
      if (8'(b) < len_q) len_mask[b*8 +: 8] = 8'hFF;
      if (8'(b) == n_cmp) tail_mask[b*8 +: 8] = 8'hFF;
    end
  end

  // Cell chain.
  nket_pkg::probe_t chain [TABLE_DEPTH+1];
  logic hits [TABLE_DEPTH];
  logic launch;
  assign launch = (state_q == StRead) &&
                  (cmd_q == nket_pkg::CmdFind || cmd_q == nket_pkg::CmdDeclare);
  always_comb begin
    chain[0].name      = name_q;
    chain[0].mask      = cmp_mask;
    chain[0].tail_zero = n_cmp < 8'(CMP);
    chain[0].active    = launch && (len_q != 8'd0);
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    nket_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .probe_i (chain[g]),
      .stored_i(names_q[g]),
      .tail_i  (tail_mask),
      .live_i  (CW'(g) < count_q),
      .probe_o (chain[g+1]),
      .hit_o   (hits[g])
    );
  end

  // Cell walk_q reports its hit this cycle.
  logic cur_hit;
  always_comb begin
    cur_hit = 1'b0;
    for (int k = 0; k < TABLE_DEPTH; k++)
      if (walk_q[IW-1:0] == IW'(k)) cur_hit = hits[k];
  end

  assign busy = (state_q != StIdle);

  // Sequence commands.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (start) state_d = StRead;
      StRead: state_d = launch ? StWalk : StDone;
      StWalk: if ({24'd0, walk_q} == TABLE_DEPTH - 1) state_d = StDone;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  // Capture command.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      cmd_q   <= command_i;
      name_q  <= name_packed_i;
      len_q   <= name_length_i;
      idx_q   <= entry_index_i;
      pslot_q <= param_slot_i;
      ptot_q  <= param_total_i;
      rflag_q <= returns_flag_i;
      tcode_q <= type_code_in_i[TB-1:0];
      soff_q  <= start_offset_i;
      saved_q <= saved_total_i;
    end
  end

  // Parameter type memory.
  always_ff @(posedge clk_i) begin
    if (state_q == StRead && cmd_q == nket_pkg::CmdSetParam && live && pslot_ok)
      ptype_mem[{idx_w, pslot_w}] <= tcode_q;
    ptype_rd_q <= ptype_mem[{idx_w, pslot_w}];
  end

  // Walk counter and first hit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
      hit_seen_q <= 1'b0;
      hit_idx_q <= '0;
    end else if (state_q == StRead) begin
      walk_q <= '0;
      hit_seen_q <= 1'b0;
    end else if (state_q == StWalk) begin
      walk_q <= walk_q + 8'd1;
      if (cur_hit && !hit_seen_q) begin
        hit_seen_q <= 1'b1;
        hit_idx_q <= walk_q[IW-1:0];
      end
    end
  end

  logic any_hit;
  logic [IW-1:0] hit_idx;
  assign any_hit = hit_seen_q || cur_hit;
  assign hit_idx = hit_seen_q ? hit_idx_q : walk_q[IW-1:0];

  logic roll_ok;
  assign roll_ok = {24'd0, saved_q} <= 32'(count_q);
  logic snap_ok;
  assign snap_ok = snap_valid_q && ({24'd0, snap_slot_q} < {24'd0, saved_q});
  logic last_walk;
  assign last_walk = state_q == StWalk && {24'd0, walk_q} == TABLE_DEPTH - 1;
  logic decl_ok;
  assign decl_ok = last_walk && cmd_q == nket_pkg::CmdDeclare && !any_hit &&
                   len_q < 8'(NAME_BYTES) && 32'(count_q) < TABLE_DEPTH;
  logic [IW-1:0] cnt_w;
  assign cnt_w = count_q[IW-1:0];

  // Update entries; dead slots are never read, so stale data is harmless
  // except for zeroing on re-declare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      snap_valid_q <= 1'b0;
      snap_slot_q <= '0;
      snap_start_q <= '0;
      snap_pcnt_q <= '0;
      snap_rflg_q <= 1'b0;
      snap_rtype_q <= '0;
    end else if (state_q == StRead) begin
      case (cmd_q)
        nket_pkg::CmdClear: count_q <= '0;
        nket_pkg::CmdSetSig: if (live) begin
          pcnt_q[idx_w] <= ptot_q;
          rflg_q[idx_w] <= rflag_q;
          rtype_q[idx_w] <= rflag_q ? tcode_q : TB'(nket_pkg::TypeVoid);
        end
        nket_pkg::CmdSetStart: if (live) starts_q[idx_w] <= soff_q;
        nket_pkg::CmdSavepoint: snap_valid_q <= 1'b0;
        nket_pkg::CmdRollback: if (roll_ok) begin
          count_q <= CW'(saved_q);
          if (snap_ok) begin
            starts_q[snap_slot_q] <= snap_start_q;
            pcnt_q[snap_slot_q] <= snap_pcnt_q;
            rflg_q[snap_slot_q] <= snap_rflg_q;
            rtype_q[snap_slot_q] <= snap_rtype_q;
          end
          snap_valid_q <= 1'b0;
        end
        nket_pkg::CmdSnapshot: if (live) begin
          snap_valid_q <= 1'b1;
          snap_slot_q <= idx_w;
          snap_start_q <= starts_q[idx_w];
          snap_pcnt_q <= pcnt_q[idx_w];
          snap_rflg_q <= rflg_q[idx_w];
          snap_rtype_q <= rtype_q[idx_w];
        end
        default: ;
      endcase
    end else if (decl_ok) begin
      names_q[cnt_w] <= name_q & len_mask;
      starts_q[cnt_w] <= '0;
      pcnt_q[cnt_w] <= '0;
      rflg_q[cnt_w] <= 1'b0;
      count_q <= count_q + CW'(1);
    end
  end

  // Form the result.
  always_comb begin
    done_d  = 1'b0;
    found_d = -7'sd1;
    so_d    = '0;
    po_d    = '0;
    ro_d    = 1'b0;
    to_d    = '0;
    if (state_q == StRead && !launch) begin
      done_d = 1'b1;
      case (cmd_q)
        nket_pkg::CmdSetSig, nket_pkg::CmdSetStart, nket_pkg::CmdSnapshot:
          if (live) found_d = 7'(idx_q);
        nket_pkg::CmdSetParam:
          if (live && pslot_ok) found_d = 7'(idx_q);
        nket_pkg::CmdReadEntry:
          if (live) begin
            found_d = 7'(idx_q);
            so_d = starts_q[idx_w];
            po_d = pcnt_q[idx_w];
            ro_d = rflg_q[idx_w];
            to_d = 4'(rtype_q[idx_w]);
          end else begin
            so_d = nket_pkg::StartDefault;
            po_d = nket_pkg::CountDefault;
            to_d = nket_pkg::TypeVoid;
          end
        nket_pkg::CmdReadParam:
          if (live && pslot_ok) found_d = 7'(idx_q);
        default: ;
      endcase
    end else if (last_walk) begin
      done_d = 1'b1;
      if (cmd_q == nket_pkg::CmdFind)
        found_d = any_hit ? 7'(hit_idx) : -7'sd1;
      else
        found_d = decl_ok ? 7'(cnt_w) : -7'sd1;
    end
  end

  // Hold the result for its strobe cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (done_d) begin
        found_q <= found_d;
        so_q <= so_d;
        po_q <= po_d;
        ro_q <= ro_d;
        to_q <= to_d;
      end
    end
  end

  // Param type read data lands in the cycle after the read state.
  logic rdp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rdp_q <= 1'b0;
    else rdp_q <= state_q == StRead && cmd_q == nket_pkg::CmdReadParam && live && pslot_ok;
  end

  assign done_o            = done_q;
  assign found_index_o     = found_q;
  assign entry_total_o     = 7'(count_q);
  assign start_out_o       = so_q;
  assign param_total_out_o = po_q;
  assign returns_out_o     = ro_q;
  assign type_code_out_o   = rdp_q ? 4'(ptype_rd_q) : to_q;

endmodule

### hw/rtl/nket_cell.sv
// One compare cell: registers the probe, flags a match against its slot name.
module nket_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nket_pkg::probe_t probe_i,
  input  logic [63:0]     stored_i,
  input  logic [63:0]     tail_i,
  input  logic            live_i,
  output nket_pkg::probe_t probe_o,
  output logic            hit_o
);

  nket_pkg::probe_t probe_q;
  logic             hit_q;

  // Hand probe to the next cell, latch the match.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      probe_q <= probe_i;
      hit_q   <= probe_i.active && live_i &&
                 (((stored_i ^ probe_i.name) & probe_i.mask) == 64'd0) &&
                 (!probe_i.tail_zero || ((stored_i & tail_i) == 64'd0));
    end
  end

  assign probe_o = probe_q;
  assign hit_o   = hit_q;

endmodule

### tb/nket_checker.sv
`timescale 1ns / 1ps

module nket_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [3:0]         command_i,
  input  logic [63:0]        name_packed_i,
  input  logic [7:0]         name_length_i,
  input  logic [7:0]         entry_index_i,
  input  logic [7:0]         param_slot_i,
  input  logic [7:0]         param_total_i,
  input  logic               returns_flag_i,
  input  logic [3:0]         type_code_in_i,
  input  logic [15:0]        start_offset_i,
  input  logic [7:0]         saved_total_i,
  input  logic               done_i,
  input  logic signed [6:0]  found_index_i,
  input  logic [6:0]         entry_total_i,
  input  logic [15:0]        start_out_i,
  input  logic [7:0]         param_total_out_i,
  input  logic               returns_out_i,
  input  logic [3:0]         type_code_out_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int Depth   = 64;
  localparam int Params  = 8;
  localparam int CmpLen  = 7;

  typedef struct packed {
    logic signed [6:0] found;
    logic [6:0]        total;
    logic [15:0]       start;
    logic [7:0]        pcount;
    logic              returns;
    logic [3:0]        tcode;
  } table_result_t;

  // Shadow copy of the table
  logic [63:0] names_q   [Depth];
  logic [15:0] starts_q  [Depth];
  logic [7:0]  pcounts_q [Depth];
  logic        rflags_q  [Depth];
  logic [3:0]  rtypes_q  [Depth];
  logic [3:0]  ptypes_q  [Depth*Params];
  int          live_q;
  logic        snap_valid_q;
  int          snap_slot_q;
  logic [28:0] snap_fields_q;

  table_result_t expected_results[$];
  int errors;

  assign fail_count_o = errors;
  assign pending_o    = expected_results.size();

  function automatic logic [63:0] low_bytes(int n);
    if (n >= 8) return '1;
    return (64'd1 << (n * 8)) - 64'd1;
  endfunction

  function automatic int lookup_slot(logic [63:0] name, int len);
    int n;
    if (len == 0) return -1;
    n = (len < CmpLen) ? len : CmpLen;
    for (int i = 0; i < live_q; i++) begin
      if (((names_q[i] ^ name) & low_bytes(n)) != 0) continue;
      if (n < CmpLen && names_q[i][n*8 +: 8] != 8'd0) continue;
      return i;
    end
    return -1;
  endfunction

  function automatic void wipe_entry(int i);
    names_q[i]   = '0;
    starts_q[i]  = '0;
    pcounts_q[i] = '0;
    rflags_q[i]  = 1'b0;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  // Apply one transaction to the shadow table and queue its result
  task automatic predict_transaction();
    table_result_t r;
    int idx, slot, saved, found;
    logic live;
    logic [3:0] tc;
    r     = '0;
    found = -1;
    idx   = int'(entry_index_i);
    slot  = int'(param_slot_i);
    saved = int'(saved_total_i);
    tc    = type_code_in_i;
    live  = idx < live_q;
    case (command_i)
      nket_pkg::CmdClear: begin
        for (int i = 0; i < Depth; i++) wipe_entry(i);
        live_q = 0;
      end
      nket_pkg::CmdFind: found = lookup_slot(name_packed_i, int'(name_length_i));
      nket_pkg::CmdDeclare: begin
        if (name_length_i < 8 && lookup_slot(name_packed_i, int'(name_length_i)) < 0 &&
            live_q < Depth) begin
          wipe_entry(live_q);
          names_q[live_q] = name_packed_i & low_bytes(int'(name_length_i));
          found = live_q;
          live_q++;
        end
      end
      nket_pkg::CmdSetSig: if (live) begin
        pcounts_q[idx] = param_total_i;
        rflags_q[idx]  = returns_flag_i;
        rtypes_q[idx]  = returns_flag_i ? tc : nket_pkg::TypeVoid;
        found = idx;
      end
      nket_pkg::CmdSetParam: if (live && slot < Params) begin
        ptypes_q[idx*Params + slot] = tc;
        found = idx;
      end
      nket_pkg::CmdSetStart: if (live) begin
        starts_q[idx] = start_offset_i;
        found = idx;
      end
      nket_pkg::CmdReadEntry: begin
        if (live) begin
          r.start   = starts_q[idx];
          r.pcount  = pcounts_q[idx];
          r.returns = rflags_q[idx];
          r.tcode   = rtypes_q[idx];
          found = idx;
        end else begin
          r.start  = nket_pkg::StartDefault;
          r.pcount = nket_pkg::CountDefault;
          r.tcode  = nket_pkg::TypeVoid;
        end
      end
      nket_pkg::CmdReadParam: begin
        if (live && slot < Params) begin
          r.tcode = ptypes_q[idx*Params + slot];
          found = idx;
        end else begin
          r.tcode = nket_pkg::TypeUnknown;
        end
      end
      nket_pkg::CmdSavepoint: snap_valid_q = 1'b0;
      nket_pkg::CmdRollback: if (saved <= live_q) begin
        for (int i = saved; i < live_q; i++) wipe_entry(i);
        live_q = saved;
        if (snap_valid_q && snap_slot_q < live_q) begin
          starts_q[snap_slot_q]  = snap_fields_q[15:0];
          pcounts_q[snap_slot_q] = snap_fields_q[23:16];
          rflags_q[snap_slot_q]  = snap_fields_q[24];
          rtypes_q[snap_slot_q]  = snap_fields_q[28:25];
        end
        snap_valid_q = 1'b0;
      end
      nket_pkg::CmdSnapshot: if (live) begin
        snap_valid_q  = 1'b1;
        snap_slot_q   = idx;
        snap_fields_q = {rtypes_q[idx], rflags_q[idx], pcounts_q[idx], starts_q[idx]};
        found = idx;
      end
      default: ;
    endcase
    r.found = 7'(found);
    r.total = 7'(live_q);
    expected_results.push_back(r);
  endtask

  // Compare one result against the oldest expectation
  task automatic check_result();
    table_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with nothing expected", $realtime);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    if (found_index_i !== want.found) report_mismatch("found_index", found_index_i, want.found);
    if (entry_total_i !== want.total) report_mismatch("entry_total", entry_total_i, want.total);
    if (start_out_i !== want.start) report_mismatch("start_out", start_out_i, want.start);
    if (param_total_out_i !== want.pcount)
      report_mismatch("param_total_out", param_total_out_i, want.pcount);
    if (returns_out_i !== want.returns) report_mismatch("returns_out", returns_out_i, want.returns);
    if (type_code_out_i !== want.tcode) report_mismatch("type_code_out", type_code_out_i, want.tcode);
  endtask

  initial begin
    errors = 0;
    for (int i = 0; i < Depth; i++) begin
      wipe_entry(i);
      rtypes_q[i] = '0;
    end
    for (int i = 0; i < Depth*Params; i++) ptypes_q[i] = '0;
    live_q        = 0;
    snap_valid_q  = 1'b0;
    snap_slot_q   = 0;
    snap_fields_q = '0;
  end

  // Watch both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_i) check_result();
      if (start_i && !busy_i) predict_transaction();
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [3:0] CmdSpare = 4'd15;
  localparam int CycleLimit = 2000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [3:0]         command_i = '0;
  logic [63:0]        name_packed_i = '0;
  logic [7:0]         name_length_i = '0;
  logic [7:0]         entry_index_i = '0;
  logic [7:0]         param_slot_i = '0;
  logic [7:0]         param_total_i = '0;
  logic               returns_flag_i = 1'b0;
  logic [3:0]         type_code_in_i = '0;
  logic [15:0]        start_offset_i = '0;
  logic [7:0]         saved_total_i = '0;
  logic               done_o;
  logic signed [6:0]  found_index_o;
  logic [6:0]         entry_total_o;
  logic [15:0]        start_out_o;
  logic [7:0]         param_total_out_o;
  logic               returns_out_o;
  logic [3:0]         type_code_out_o;
  int                 fail_count;
  int                 pending;

  // Which type codes hold a written value; reads of others are avoided
  logic rtype_known [64];
  logic ptype_known [512];
  int   live_total;
  int   cycles;
  int   item_no;

  always #4 clk_i = ~clk_i;

  name_keyed_entry_table i_dut (.*);

  nket_checker i_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .command_i, .name_packed_i,
    .name_length_i, .entry_index_i, .param_slot_i, .param_total_i, .returns_flag_i,
    .type_code_in_i, .start_offset_i, .saved_total_i, .done_i(done_o),
    .found_index_i(found_index_o), .entry_total_i(entry_total_o),
    .start_out_i(start_out_o), .param_total_out_i(param_total_out_o),
    .returns_out_i(returns_out_o), .type_code_out_i(type_code_out_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Issue one transaction, then wait for its result
  task automatic issue(logic [3:0] op, logic [63:0] name, logic [7:0] len, logic [7:0] idx,
                       logic [7:0] pslot, logic [7:0] ptotal, logic rflag,
                       logic [3:0] tc, logic [15:0] offs, logic [7:0] saved);
    // Steer reads away from type codes never written
    if ((op == nket_pkg::CmdReadEntry || op == nket_pkg::CmdSnapshot) &&
        idx < live_total && !rtype_known[idx])
      idx = 8'($urandom_range(live_total, 255));
    if (op == nket_pkg::CmdReadParam && idx < live_total && pslot < 8 &&
        !ptype_known[idx*8 + pslot])
      pslot = 8'($urandom_range(8, 255));
    if (op == nket_pkg::CmdSetSig && idx < live_total) rtype_known[idx] = 1'b1;
    if (op == nket_pkg::CmdSetParam && idx < live_total && pslot < 8)
      ptype_known[idx*8 + pslot] = 1'b1;
    command_i      <= op;
    name_packed_i  <= name;
    name_length_i  <= len;
    entry_index_i  <= idx;
    param_slot_i   <= pslot;
    param_total_i  <= ptotal;
    returns_flag_i <= rflag;
    type_code_in_i <= tc;
    start_offset_i <= offs;
    saved_total_i  <= saved;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
    start <= 1'b0;
    do @(posedge clk_i); while (!done_o);
    live_total = int'(entry_total_o);
    item_no++;
    // Idle now and then, except in a long quiet stretch
    if ((item_no < 500 || item_no > 750) && $urandom_range(0, 99) < 26)
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pool_name(int len);
    logic [63:0] n;
    n = {$urandom, $urandom};
    for (int b = 0; b < 8; b++)
      n[b*8 +: 8] = (b < len) ? 8'(8'h61 + $urandom_range(0, 2)) : 8'h00;
    if ($urandom_range(0, 3) == 0) n[63:32] = n[63:32] | $urandom;
    return n;
  endfunction

  task automatic random_item();
    int sel, len, idx;
    logic [3:0] op;
    logic [7:0] saved;
    sel = $urandom_range(0, 99);
    if (sel < 22)      op = nket_pkg::CmdDeclare;
    else if (sel < 40) op = nket_pkg::CmdFind;
    else if (sel < 50) op = nket_pkg::CmdSetSig;
    else if (sel < 60) op = nket_pkg::CmdSetParam;
    else if (sel < 66) op = nket_pkg::CmdSetStart;
    else if (sel < 76) op = nket_pkg::CmdReadEntry;
    else if (sel < 84) op = nket_pkg::CmdReadParam;
    else if (sel < 88) op = nket_pkg::CmdSavepoint;
    else if (sel < 93) op = nket_pkg::CmdRollback;
    else if (sel < 97) op = nket_pkg::CmdSnapshot;
    else if (sel < 98) op = nket_pkg::CmdClear;
    else               op = 4'($urandom_range(11, 15));
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
    idx = (live_total > 0 && $urandom_range(0, 4) != 0) ?
          $urandom_range(0, live_total - 1) : $urandom_range(0, 255);
    saved = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) :
            8'($urandom_range(0, live_total));
    issue(op, ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : pool_name(len), 8'(len),
          8'(idx),
          $urandom_range(0, 4) == 0 ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7)),
          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
          16'($urandom_range(0, 65535)), saved);
  endtask

  initial begin
    for (int i = 0; i < 64; i++) rtype_known[i] = 1'b0;
    for (int i = 0; i < 512; i++) ptype_known[i] = 1'b0;
    live_total = 0;
    cycles = 0;
    item_no = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty and long names, duplicates, sets and reads, undo paths
    issue(nket_pkg::CmdFind, 64'h0, 8'd0, 0, 0, 0, 0, 0, 0, 0);
    issue(nket_pkg::CmdDeclare, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 0, 0, 0, 0, 0, 0, 0);
    issue(nket_pkg::CmdDeclare, 64'h6867_6665_6463_6261, 8'd8, 0, 0, 0, 0, 0, 0, 0);
    issue(nket_pkg::CmdDeclare, 64'hFFFF_FF00_0000_0061, 8'd1, 0, 0, 0, 0, 0, 0, 0);
    issue(nket_pkg::CmdDeclare, 64'h0000_0000_0000_0061, 8'd1, 0, 0, 0, 0, 0, 0, 0);
    issue(nket_pkg::CmdDeclare, 64'h0067_6665_6463_6261, 8'd7, 0, 0, 0, 0, 0, 0, 0);
    issue(nket_pkg::CmdFind, 64'hAA67_6665_6463_6261, 8'd255, 0, 0, 0, 0, 0, 0, 0);
    issue(nket_pkg::CmdFind, 64'hFFFF_FFFF_FFFF_FF61, 8'd1, 0, 0, 0, 0, 0, 0, 0);
    issue(nket_pkg::CmdSetSig, 0, 0, 8'd1, 0, 8'd255, 1'b0, 4'd15, 0, 0);
    issue(nket_pkg::CmdSetSig, 0, 0, 8'd2, 0, 8'd0, 1'b1, 4'd15, 0, 0);
    issue(nket_pkg::CmdSetSig, 0, 0, 8'd0, 0, 8'd3, 1'b1, 4'd5, 0, 0);
    issue(nket_pkg::CmdSetParam, 0, 0, 8'd1, 8'd7, 0, 0, 4'd15, 0, 0);
    issue(nket_pkg::CmdSetParam, 0, 0, 8'd1, 8'd8, 0, 0, 4'd9, 0, 0);
    issue(nket_pkg::CmdSetStart, 0, 0, 8'd1, 0, 0, 0, 0, 16'hFFFF, 0);
    issue(nket_pkg::CmdReadEntry, 0, 0, 8'd1, 0, 0, 0, 0, 0, 0);
    issue(nket_pkg::CmdReadParam, 0, 0, 8'd1, 8'd7, 0, 0, 0, 0, 0);
    issue(nket_pkg::CmdReadEntry, 0, 0, 8'd255, 0, 0, 0, 0, 0, 0);
    issue(nket_pkg::CmdReadParam, 0, 0, 8'd1, 8'd255, 0, 0, 0, 0, 0);
    issue(nket_pkg::CmdSavepoint, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(nket_pkg::CmdSnapshot, 0, 0, 8'd1, 0, 0, 0, 0, 0, 0);
    issue(nket_pkg::CmdSetSig, 0, 0, 8'd1, 0, 8'd4, 1'b1, 4'd3, 0, 0);
    issue(nket_pkg::CmdRollback, 0, 0, 0, 0, 0, 0, 0, 0, 8'd255);
    issue(nket_pkg::CmdRollback, 0, 0, 0, 0, 0, 0, 0, 0, 8'd3);
    issue(nket_pkg::CmdReadEntry, 0, 0, 8'd1, 0, 0, 0, 0, 0, 0);
    issue(CmdSpare, '1, '1, '1, '1, '1, 1'b1, '1, '1, '1);
    // Fill the table, then overflow it
    for (int i = 0; i < 66; i++)
      issue(nket_pkg::CmdDeclare, 64'h7A00 | 64'(i), 8'd2, 0, 0, 0, 0, 0, 0, 0);
    issue(nket_pkg::CmdClear, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    repeat (1150) random_item();

    // Drain and settle
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/nket_pkg.sv
hw/rtl/nket_cell.sv
hw/rtl/name_keyed_entry_table.sv
tb/nket_checker.sv
tb/tb_top.sv
